// ===== design/assert_macros.svh =====
// Assertion macros shared by the debouncer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/abd_pkg.sv =====
// Types and constants for the analog button debouncer.
package abd_pkg;

  localparam int FieldSampleW = 10;
  localparam int CfgDataW     = 16;
  localparam int CfgIndexW    = 3;
  localparam int TimeW        = 32;

  // Register indexes
  localparam logic [CfgIndexW-1:0] REG_LEVEL_THRESHOLD = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_PULLUP_WIRING   = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_COUNT_LIMIT     = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_SAMPLE_INTERVAL = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_HOLD_MS         = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_REPEAT_FIRST_MS = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_REPEAT_NEXT_MS  = 3'd6;

  typedef struct packed {
    logic [FieldSampleW-1:0] adc_sample;
    logic                    take_pushed;
    logic                    take_tap;
    logic                    poll_repeat;
  } in_item_t;

  typedef struct packed {
    logic             pressed;
    logic             pushed_event;
    logic [TimeW-1:0] tap_duration;
    logic             held_now;
    logic             repeat_pulse;
  } out_item_t;

  typedef struct packed {
    logic [FieldSampleW-1:0] level_threshold;
    logic                    pullup_wiring;
    logic [7:0]              count_limit;
    logic [7:0]              sample_interval;
    logic [15:0]             hold_ms;
    logic [15:0]             repeat_first_ms;
    logic [15:0]             repeat_next_ms;
  } cfg_t;

endpackage

// ===== design/abd_cfg_regs.sv =====
// Configuration register file for the debouncer.
module abd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [abd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [abd_pkg::CfgDataW-1:0]  cfg_wdata,
  output abd_pkg::cfg_t                 cfg
);

  abd_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.level_threshold <= 10'd512;
      regs.pullup_wiring   <= 1'b1;
      regs.count_limit     <= 8'd5;
      regs.sample_interval <= 8'd10;
      regs.hold_ms         <= 16'd1000;
      regs.repeat_first_ms <= 16'd500;
      regs.repeat_next_ms  <= 16'd100;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        abd_pkg::REG_LEVEL_THRESHOLD:
          regs.level_threshold <= cfg_wdata[abd_pkg::FieldSampleW-1:0];
        abd_pkg::REG_PULLUP_WIRING:   regs.pullup_wiring   <= cfg_wdata[0];
        abd_pkg::REG_COUNT_LIMIT:     regs.count_limit     <= cfg_wdata[7:0];
        abd_pkg::REG_SAMPLE_INTERVAL: regs.sample_interval <= cfg_wdata[7:0];
        abd_pkg::REG_HOLD_MS:         regs.hold_ms         <= cfg_wdata;
        abd_pkg::REG_REPEAT_FIRST_MS: regs.repeat_first_ms <= cfg_wdata;
        abd_pkg::REG_REPEAT_NEXT_MS:  regs.repeat_next_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== design/abd_core.sv =====
// Debounce state, press/tap latches, hold and auto-repeat logic for one tick.
module abd_core #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  abd_pkg::cfg_t       cfg,
  input  logic                fire,
  input  abd_pkg::in_item_t   item,
  output abd_pkg::out_item_t  result
);

  localparam int CmpW = (SAMPLE_BITS < abd_pkg::FieldSampleW) ?
                        SAMPLE_BITS : abd_pkg::FieldSampleW;
  localparam int TW = abd_pkg::TimeW;

  // tick_ms holds the clock value the next tick will see
  logic [TW-1:0] tick_ms;
  logic [TW-1:0] last_sample_ms;
  logic          debounced_state;
  logic [8:0]    mismatch_count;
  logic          pushed_latch;
  logic [TW-1:0] on_duration;
  logic [TW-1:0] change_time_ms;
  logic          repeat_started;
  logic [TW-1:0] next_repeat_ms;

  logic          sample_due;
  logic          raw;
  logic [8:0]    mm_inc;
  logic          mismatch;
  logic          flip;
  logic          to_pressed;
  logic          to_released;
  logic          state_new;
  logic          pushed_new;
  logic [TW-1:0] on_dur_new;
  logic          held_keep;
  logic          held_flip;
  logic          pulse;
  logic [15:0]   repeat_step;

  always_comb begin
    sample_due = tick_ms > (last_sample_ms + {24'd0, cfg.sample_interval});
    if (cfg.pullup_wiring)
      raw = item.adc_sample[CmpW-1:0] <= cfg.level_threshold[CmpW-1:0];
    else
      raw = item.adc_sample[CmpW-1:0] >  cfg.level_threshold[CmpW-1:0];
    mismatch    = sample_due && (raw != debounced_state);
    mm_inc      = mismatch_count + 9'd1;
    flip        = mismatch && (mm_inc > {1'b0, cfg.count_limit});
    to_pressed  = flip && !debounced_state;
    to_released = flip && debounced_state;
    state_new   = debounced_state ^ flip;
    pushed_new  = pushed_latch | to_pressed;
    on_dur_new  = to_released ? (tick_ms - change_time_ms) : on_duration;
    // after a flip the change time is this tick; both cases computed side by side
    held_keep   = tick_ms > (change_time_ms + {16'd0, cfg.hold_ms});
    held_flip   = tick_ms > (tick_ms + {16'd0, cfg.hold_ms});
    // a flip either releases or restarts the schedule at now: no pulse either way
    pulse       = item.poll_repeat && !flip && debounced_state &&
                  (tick_ms > next_repeat_ms);
    repeat_step = repeat_started ? cfg.repeat_next_ms : cfg.repeat_first_ms;
  end

  always_comb begin
    result.pressed      = state_new;
    result.pushed_event = pushed_new;
    result.tap_duration = on_dur_new;
    result.held_now     = state_new && (flip ? held_flip : held_keep);
    result.repeat_pulse = pulse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms         <= {{(TW-1){1'b0}}, 1'b1};
      last_sample_ms  <= '0;
      debounced_state <= 1'b0;
      mismatch_count  <= '0;
      pushed_latch    <= 1'b0;
      on_duration     <= '0;
      change_time_ms  <= '0;
      repeat_started  <= 1'b0;
      next_repeat_ms  <= '0;
    end else if (fire) begin
      tick_ms         <= tick_ms + 32'd1;
      debounced_state <= state_new;
      pushed_latch    <= pushed_new && !item.take_pushed;
      on_duration     <= item.take_tap ? '0 : on_dur_new;
      if (sample_due)
        last_sample_ms <= tick_ms;
      if (sample_due)
        mismatch_count <= (mismatch && !flip) ? mm_inc : 9'd0;
      if (flip)
        change_time_ms <= tick_ms;
      if (to_pressed) begin
        repeat_started <= 1'b0;
        next_repeat_ms <= tick_ms;
      end else if (pulse) begin
        repeat_started <= 1'b1;
        next_repeat_ms <= next_repeat_ms + {16'd0, repeat_step};
      end
    end
  end

endmodule

// ===== design/analog_button_debouncer.sv =====
// Analog button debouncer top level: input stage, tick logic and result register.
// Path: an accepted beat waits in the input stage register and is written to out_data
// once the result register is free or draining; out_ready low holds it in the stage.
// Throughput: one beat per cycle when not stalled; single-pass tick logic between the registers.
// Reset (rst, synchronous): empties both stages, returns state and registers to defaults.
`include "assert_macros.svh"

module analog_button_debouncer #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  abd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output abd_pkg::out_item_t            out_data,
  input  logic                          cfg_wr_en,
  input  logic [abd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [abd_pkg::CfgDataW-1:0]  cfg_wdata
);

  abd_pkg::cfg_t      cfg;
  abd_pkg::in_item_t  stage_item;
  logic               stage_valid;
  logic               stage_fire;
  abd_pkg::out_item_t result;

  abd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  abd_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (stage_fire),
    .item   (stage_item),
    .result (result)
  );

  // a staged beat moves on whenever the result register is free or drains
  assign stage_fire = stage_valid && (!out_valid || out_ready);
  assign in_ready   = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      out_data <= result;
    end
  end

  `ASSERT_IMPLY(a_pulse_needs_press, clk, rst, out_valid && out_data.repeat_pulse, out_data.pressed)
  `ASSERT_IMPLY(a_held_needs_press, clk, rst, out_valid && out_data.held_now, out_data.pressed)
  `ASSERT_IMPLY(a_full_stall_blocks, clk, rst, stage_valid && out_valid && !out_ready, !in_ready)
  `ASSERT_NEXT(a_drain_empties, clk, rst, out_valid && out_ready && !stage_fire, !out_valid)

endmodule
